>>> hdl/lruhc_pkg.sv
`default_nettype none

package lruhc_pkg;

    // Fixed field widths of the request and result words.
    localparam int KEY_W        = 32;
    localparam int SLOT_FIELD_W = 3;
    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 40;

    // Age stamps: 0 marks a slot never used, 1 a flushed slot, 2 and up the time of last use.
    localparam int              STAMP_W       = 40;
    localparam logic [STAMP_W-1:0] STAMP_NEVER   = STAMP_W'(0);
    localparam logic [STAMP_W-1:0] STAMP_FLUSHED = STAMP_W'(1);
    localparam logic [STAMP_W-1:0] TICK_START    = STAMP_W'(2);
    localparam logic [STAMP_W-1:0] STAMP_MAX     = {STAMP_W{1'b1}};

    // Defaults for the top-level parameters.
    localparam int DEF_SLOTS    = 8;
    localparam int DEF_KEY_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ACCESS    = 2'd0,
        CMD_LOOKUP    = 2'd1,
        CMD_FLUSH     = 2'd2,
        CMD_FLUSH_ALL = 2'd3
    } lruhc_cmd_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request, compare keys, load the stamp tree
        logic reduce;   // fold one level of the minimum-stamp tree
        logic commit;   // update the slots and load the result register
    } lruhc_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/lruhc_ctrl.sv
`default_nettype none

module lruhc_ctrl
    import lruhc_pkg::*;
#(
    parameter int SLOTS = DEF_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output lruhc_ctrl_t      ctrl
);

    localparam int LEVELS = (SLOTS > 1) ? $clog2(SLOTS) : 0;
    localparam int LVL_W  = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    state_t             state_reg;
    logic [LVL_W-1:0]   lvl_reg;
    logic               m_tvalid_reg;
    logic               out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    assign ctrl.capture = (state_reg == ST_IDLE) && s_tvalid;
    assign ctrl.reduce  = (state_reg == ST_SCAN);
    assign ctrl.commit  = (state_reg == ST_COMMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            lvl_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A commit refills the result register even as it is being emptied.
            if ((state_reg == ST_COMMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        lvl_reg   <= '0;
                        state_reg <= (LEVELS == 0) ? ST_COMMIT : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    lvl_reg <= lvl_reg + 1'b1;
                    if (lvl_reg == LVL_W'(LEVELS - 1)) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    // The result register is free or is being emptied this cycle.
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/lruhc_datapath.sv
`default_nettype none

module lruhc_datapath
    import lruhc_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire lruhc_ctrl_t            ctrl,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    output logic [M_TDATA_W-1:0]        m_tdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot contents.
    logic [KEY_BITS-1:0]  key_reg   [SLOTS];
    logic [SLOTS-1:0]     valid_reg;
    logic [STAMP_W-1:0]   stamp_reg [SLOTS];
    logic [STAMP_W-1:0]   tick_reg;

    // Request held from capture to commit.
    lruhc_cmd_t           req_cmd_reg;
    logic [KEY_BITS-1:0]  req_key_reg;
    logic                 req_open_reg;
    logic                 req_hit_reg;
    logic [SLOT_W-1:0]    req_match_reg;

    // Minimum-stamp tree; entry 0 holds the victim after the last level.
    logic [SLOT_W-1:0]    cand_idx_reg   [SLOTS];
    logic [STAMP_W-1:0]   cand_stamp_reg [SLOTS];
    logic [SLOT_W-1:0]    red_idx        [SLOTS];
    logic [STAMP_W-1:0]   red_stamp      [SLOTS];

    logic [M_TDATA_W-1:0] out_data_reg;

    // Request key trimmed or zero-extended to the stored width.
    logic [KEY_BITS+KEY_W-1:0] in_key_wide;
    logic [KEY_BITS-1:0]       in_key;
    logic                      match_hit;
    logic [SLOT_W-1:0]         match_idx;

    logic [SLOT_W-1:0]         victim;
    logic                      o_hit;
    logic [SLOT_W-1:0]         o_slot;
    logic                      o_installed;
    logic                      o_ev_valid;
    logic [KEY_BITS-1:0]       o_ev_key;
    logic                      o_failed;
    logic                      wr_touch;
    logic                      wr_flush;
    logic                      wr_install;
    logic                      flush_all;
    logic [SLOT_W-1:0]         wr_idx;

    logic [SLOT_W+SLOT_FIELD_W-1:0] slot_wide;
    logic [KEY_BITS+KEY_W-1:0]      ev_key_wide;

    assign in_key_wide = {{KEY_BITS{1'b0}}, s_tdata[KEY_W-1:0]};
    assign in_key      = in_key_wide[KEY_BITS-1:0];

    // Parallel compare against every valid slot; the lowest index wins.
    always_comb begin
        match_hit = 1'b0;
        match_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i] && (key_reg[i] == in_key)) begin
                match_hit = 1'b1;
                match_idx = SLOT_W'(i);
            end
        end
    end

    // One tree level: entry i takes the smaller of entries 2i and 2i+1.
    // The left entry always covers lower slots, so it keeps ties.
    for (genvar g = 0; g < SLOTS; g++) begin : g_red
        if (2 * g + 1 < SLOTS) begin : g_pair
            always_comb begin
                if (cand_stamp_reg[2*g+1] < cand_stamp_reg[2*g]) begin
                    red_idx[g]   = cand_idx_reg[2*g+1];
                    red_stamp[g] = cand_stamp_reg[2*g+1];
                end else begin
                    red_idx[g]   = cand_idx_reg[2*g];
                    red_stamp[g] = cand_stamp_reg[2*g];
                end
            end
        end else if (2 * g < SLOTS) begin : g_single
            assign red_idx[g]   = cand_idx_reg[2*g];
            assign red_stamp[g] = cand_stamp_reg[2*g];
        end else begin : g_keep
            assign red_idx[g]   = cand_idx_reg[g];
            assign red_stamp[g] = cand_stamp_reg[g];
        end
    end

    assign victim = cand_idx_reg[0];

    always_comb begin
        o_hit       = 1'b0;
        o_slot      = '0;
        o_installed = 1'b0;
        o_ev_valid  = 1'b0;
        o_ev_key    = '0;
        o_failed    = 1'b0;
        wr_touch    = 1'b0;
        wr_flush    = 1'b0;
        wr_install  = 1'b0;
        flush_all   = 1'b0;
        wr_idx      = req_match_reg;
        case (req_cmd_reg)
            CMD_FLUSH_ALL: begin
                flush_all = 1'b1;
            end
            CMD_LOOKUP: begin
                if (req_hit_reg) begin
                    o_hit  = 1'b1;
                    o_slot = req_match_reg;
                end
            end
            CMD_FLUSH: begin
                if (req_hit_reg) begin
                    o_hit    = 1'b1;
                    o_slot   = req_match_reg;
                    wr_flush = 1'b1;
                end
            end
            CMD_ACCESS: begin
                if (req_hit_reg) begin
                    o_hit    = 1'b1;
                    o_slot   = req_match_reg;
                    wr_touch = 1'b1;
                end else if (req_open_reg) begin
                    wr_idx      = victim;
                    wr_touch    = 1'b1;
                    wr_install  = 1'b1;
                    o_slot      = victim;
                    o_installed = 1'b1;
                    o_ev_valid  = valid_reg[victim];
                    o_ev_key    = valid_reg[victim] ? key_reg[victim] : '0;
                end else begin
                    o_failed = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign slot_wide   = {{SLOT_FIELD_W{1'b0}}, o_slot};
    assign ev_key_wide = {{KEY_W{1'b0}}, o_ev_key};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                stamp_reg[i] <= STAMP_NEVER;
            end
            tick_reg <= TICK_START;
        end else if (ctrl.commit) begin
            if (flush_all) begin
                valid_reg <= '0;
                for (int i = 0; i < SLOTS; i++) begin
                    stamp_reg[i] <= STAMP_FLUSHED;
                end
            end
            if (wr_flush) begin
                valid_reg[wr_idx] <= 1'b0;
                stamp_reg[wr_idx] <= STAMP_FLUSHED;
            end
            if (wr_install) begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (wr_touch) begin
                stamp_reg[wr_idx] <= tick_reg;
                // The event counter sticks at its top value.
                if (tick_reg != STAMP_MAX) begin
                    tick_reg <= tick_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            req_cmd_reg   <= lruhc_cmd_t'(s_tuser);
            req_key_reg   <= in_key;
            req_open_reg  <= s_tdata[KEY_W];
            req_hit_reg   <= match_hit;
            req_match_reg <= match_idx;
            for (int i = 0; i < SLOTS; i++) begin
                cand_idx_reg[i]   <= SLOT_W'(i);
                cand_stamp_reg[i] <= stamp_reg[i];
            end
        end else if (ctrl.reduce) begin
            for (int i = 0; i < SLOTS; i++) begin
                cand_idx_reg[i]   <= red_idx[i];
                cand_stamp_reg[i] <= red_stamp[i];
            end
        end
        if (ctrl.commit) begin
            if (wr_install) begin
                key_reg[wr_idx] <= req_key_reg;
            end
            out_data_reg <= {1'b0, o_failed, ev_key_wide[KEY_W-1:0], o_ev_valid,
                             o_installed, slot_wide[SLOT_FIELD_W-1:0], o_hit};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/lru_handle_cache_unit.sv
`default_nettype none

// Fully associative key cache of SLOTS entries with least-recently-used
// replacement. Each request word gives one result word, in order. At the
// accepting edge the key is compared against all slots at once and the age
// stamps are loaded, the minimum-stamp tree then folds one level per cycle,
// and a final commit step updates the slots and fills the result register.
// Requests are handled one at a time; the next one is taken while the
// previous result still waits in the output register, but the commit of a
// request holds until that register is free.

module lru_handle_cache_unit
    import lruhc_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // key[31:0], open_ok[32], zero[39:33]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // cmd[1:0]
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // hit[0], slot[3:1], installed[4], evicted_valid[5], evicted_key[37:6],
    // failed[38], zero[39]
    output logic [M_TDATA_W-1:0]        m_tdata
);

    lruhc_ctrl_t ctrl;

    lruhc_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    lruhc_datapath #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
